// ----- rtl/hrl_pkg.sv -----
package hrl_pkg;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NF   = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam int unsigned SURR_LO = 32'hD800;
  localparam int unsigned SURR_HI = 32'hDFFF;

  localparam int unsigned REC_IDX_W = 12;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_INIT,
    OP_BCHK,
    OP_DCHK,
    OP_SR0,
    OP_SR1,
    OP_SR2,
    OP_DR0,
    OP_DR1,
    OP_DR2,
    OP_SL,
    OP_C1A,
    OP_C1B,
    OP_C2,
    OP_CMP,
    OP_SE,
    OP_BS0,
    OP_BS1,
    OP_BS2
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   res_we;
  } dp_cmd_t;

  typedef struct packed {
    logic tot_zero;
    logic rdy;
    logic init_last;
    logic i_nz;
    logic i_gt1;
    logic pos_lt_half;
    logic has_c2;
    logic root_ge;
    logic lo_lt_hi;
    logic key_eq;
  } dp_stat_t;

endpackage

// ----- rtl/hash_reverse_index_lookup.sv -----
// Hash reverse-index lookup.
// Request channel (in_valid_i/in_ready_o): op_i = 0 appends a 128-bit hash
// as the next record, op_i = 1 looks a hash up. Response channel
// (out_valid_o/out_ready_i): one status/record_index per request.
// A load's response is registered the cycle after it is accepted. A lookup
// walks a binary search over the sorted index RAM; each probe reads the
// index, reads the hash and compares. The first lookup after loading also
// builds the index: a fill of the index RAM, then a heap sort whose sift
// steps are bounded by the one read port of the index RAM.
// One request is in flight at a time; a new request is taken once the
// previous response is in the output register and that register is free
// or being read in the same cycle. A stalled receiver holds the response
// and blocks further requests.
// Reset empties the table and drops the index; RAM contents are not cleared.
module hash_reverse_index_lookup #(
  parameter int unsigned MAX_RECORDS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [63:0] hash_high_i,
  input  logic [63:0] hash_low_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [11:0] record_index_o
);

  hrl_pkg::dp_cmd_t  cmd;
  hrl_pkg::dp_stat_t stat;

  hrl_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i,
    .out_valid_o, .out_ready_i, .stat_i(stat), .cmd_o(cmd)
  );

  hrl_dp #(.MAX_RECORDS(MAX_RECORDS)) u_dp (
    .clk_i, .rst_ni, .op_i, .hash_high_i, .hash_low_i,
    .status_o, .record_index_o, .cmd_i(cmd), .stat_o(stat)
  );

  a_load_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !op_i |=> out_valid_o && status_o != hrl_pkg::ST_NF)
    else $error("load request without response");

  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != hrl_pkg::ST_OK |-> record_index_o == '0)
    else $error("nonzero record index on failure");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("undefined status code");

endmodule

// ----- rtl/hrl_ram.sv -----
module hrl_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/hrl_ctrl.sv -----
module hrl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              op_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  hrl_pkg::dp_stat_t stat_i,
  output hrl_pkg::dp_cmd_t  cmd_o
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_INIT = 5'd1;
  localparam logic [4:0] S_BCHK = 5'd2;
  localparam logic [4:0] S_DCHK = 5'd3;
  localparam logic [4:0] S_SR0  = 5'd4;
  localparam logic [4:0] S_SR1  = 5'd5;
  localparam logic [4:0] S_SR2  = 5'd6;
  localparam logic [4:0] S_DR0  = 5'd7;
  localparam logic [4:0] S_DR1  = 5'd8;
  localparam logic [4:0] S_DR2  = 5'd9;
  localparam logic [4:0] S_SL   = 5'd10;
  localparam logic [4:0] S_C1A  = 5'd11;
  localparam logic [4:0] S_C1B  = 5'd12;
  localparam logic [4:0] S_C2   = 5'd13;
  localparam logic [4:0] S_CMP  = 5'd14;
  localparam logic [4:0] S_SE   = 5'd15;
  localparam logic [4:0] S_BS0  = 5'd16;
  localparam logic [4:0] S_BS1  = 5'd17;
  localparam logic [4:0] S_BS2  = 5'd18;

  logic [4:0] state_q, state_d;
  logic       drain_q, drain_d;
  logic       ovld_q, ovld_d;
  logic       acc;

  assign in_ready_o  = (state_q == S_IDLE) && (!ovld_q || out_ready_i);
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = ovld_q;

  always_comb begin
    state_d      = state_q;
    drain_d      = drain_q;
    cmd_o.op     = hrl_pkg::OP_NOP;
    cmd_o.res_we = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          cmd_o.op = hrl_pkg::OP_ACCEPT;
          drain_d  = 1'b0;
          if (!op_i || stat_i.tot_zero) begin
            cmd_o.res_we = 1'b1;
          end else if (!stat_i.rdy) begin
            state_d = S_INIT;
          end else begin
            state_d = S_BS0;
          end
        end
      end
      S_INIT: begin
        cmd_o.op = hrl_pkg::OP_INIT;
        if (stat_i.init_last) state_d = S_BCHK;
      end
      S_BCHK: begin
        cmd_o.op = hrl_pkg::OP_BCHK;
        if (stat_i.i_nz) begin
          state_d = S_SR0;
        end else begin
          drain_d = 1'b1;
          state_d = S_DCHK;
        end
      end
      S_DCHK: begin
        cmd_o.op = hrl_pkg::OP_DCHK;
        state_d  = stat_i.i_gt1 ? S_DR0 : S_BS0;
      end
      S_SR0: begin
        cmd_o.op = hrl_pkg::OP_SR0;
        state_d  = S_SR1;
      end
      S_SR1: begin
        cmd_o.op = hrl_pkg::OP_SR1;
        state_d  = S_SR2;
      end
      S_SR2: begin
        cmd_o.op = hrl_pkg::OP_SR2;
        state_d  = S_SL;
      end
      S_DR0: begin
        cmd_o.op = hrl_pkg::OP_DR0;
        state_d  = S_DR1;
      end
      S_DR1: begin
        cmd_o.op = hrl_pkg::OP_DR1;
        state_d  = S_DR2;
      end
      S_DR2: begin
        cmd_o.op = hrl_pkg::OP_DR2;
        state_d  = S_SR2;
      end
      S_SL: begin
        cmd_o.op = hrl_pkg::OP_SL;
        state_d  = stat_i.pos_lt_half ? S_C1A : S_SE;
      end
      S_C1A: begin
        cmd_o.op = hrl_pkg::OP_C1A;
        state_d  = S_C1B;
      end
      S_C1B: begin
        cmd_o.op = hrl_pkg::OP_C1B;
        state_d  = stat_i.has_c2 ? S_C2 : S_CMP;
      end
      S_C2: begin
        cmd_o.op = hrl_pkg::OP_C2;
        state_d  = S_CMP;
      end
      S_CMP: begin
        cmd_o.op = hrl_pkg::OP_CMP;
        state_d  = stat_i.root_ge ? S_SE : S_SL;
      end
      S_SE: begin
        cmd_o.op = hrl_pkg::OP_SE;
        state_d  = drain_q ? S_DCHK : S_BCHK;
      end
      S_BS0: begin
        cmd_o.op = hrl_pkg::OP_BS0;
        if (stat_i.lo_lt_hi) begin
          state_d = S_BS1;
        end else begin
          cmd_o.res_we = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_BS1: begin
        cmd_o.op = hrl_pkg::OP_BS1;
        state_d  = S_BS2;
      end
      S_BS2: begin
        cmd_o.op = hrl_pkg::OP_BS2;
        if (stat_i.key_eq) begin
          cmd_o.res_we = 1'b1;
          state_d      = S_IDLE;
        end else begin
          state_d = S_BS0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ovld_d = ovld_q;
    if (out_ready_i) ovld_d = 1'b0;
    if (cmd_o.res_we) ovld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      drain_q <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      drain_q <= drain_d;
      ovld_q  <= ovld_d;
    end
  end

endmodule

// ----- rtl/hrl_dp.sv -----
module hrl_dp #(
  parameter int unsigned MAX_RECORDS = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              op_i,
  input  logic [63:0]       hash_high_i,
  input  logic [63:0]       hash_low_i,
  output logic [1:0]        status_o,
  output logic [11:0]       record_index_o,
  input  hrl_pkg::dp_cmd_t  cmd_i,
  output hrl_pkg::dp_stat_t stat_o
);

  localparam int unsigned IDX_W = $clog2(MAX_RECORDS);
  localparam int unsigned CNT_W = $clog2(MAX_RECORDS + 1);
  localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_RECORDS);
  localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

  logic [CNT_W-1:0] tot_q, tot_d, i_q, i_d, cnt_q, cnt_d, pos_q, pos_d, chd_q, chd_d;
  logic [CNT_W-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic             rdy_q, rdy_d;
  logic [63:0]      hh_q, hh_d, hl_q, hl_d;
  logic [IDX_W-1:0] rec_q, rec_d, crec_q, crec_d, c2rec_q, c2rec_d;
  logic [127:0]     rkey_q, rkey_d, ckey_q, ckey_d;
  logic [1:0]       st_q, st_d;
  logic [11:0]      ridx_q, ridx_d;

  logic             idx_we, hash_we;
  logic [IDX_W-1:0] idx_waddr, idx_wdata, idx_raddr, idx_rdata, hash_waddr;
  logic [63:0]      hh_rdata, hl_rdata;
  logic [127:0]     hkey, in_key;
  logic [CNT_W-1:0] tot_eff, mid, im1, chd_nx;

  hrl_ram #(.WIDTH(IDX_W), .DEPTH(MAX_RECORDS)) u_idx (
    .clk_i, .we_i(idx_we), .waddr_i(idx_waddr), .wdata_i(idx_wdata),
    .raddr_i(idx_raddr), .rdata_o(idx_rdata)
  );
  hrl_ram #(.WIDTH(64), .DEPTH(MAX_RECORDS)) u_hh (
    .clk_i, .we_i(hash_we), .waddr_i(hash_waddr), .wdata_i(hh_q),
    .raddr_i(idx_rdata), .rdata_o(hh_rdata)
  );
  hrl_ram #(.WIDTH(64), .DEPTH(MAX_RECORDS)) u_hl (
    .clk_i, .we_i(hash_we), .waddr_i(hash_waddr), .wdata_i(hl_q),
    .raddr_i(idx_rdata), .rdata_o(hl_rdata)
  );

  assign hkey    = {hh_rdata, hl_rdata};
  assign in_key  = {hh_q, hl_q};
  assign tot_eff = rdy_q ? '0 : tot_q;
  assign mid     = lo_q + ((hi_q - lo_q) >> 1);
  assign im1     = i_q - ONE;
  assign chd_nx  = {pos_q[CNT_W-2:0], 1'b1};

  assign stat_o.tot_zero    = (tot_q == '0);
  assign stat_o.rdy         = rdy_q;
  assign stat_o.init_last   = (i_q == tot_q - ONE);
  assign stat_o.i_nz        = (i_q != '0);
  assign stat_o.i_gt1       = (i_q > ONE);
  assign stat_o.pos_lt_half = (pos_q < (cnt_q >> 1));
  assign stat_o.has_c2      = ((chd_q + ONE) < cnt_q);
  assign stat_o.root_ge     = (rkey_q >= ckey_q);
  assign stat_o.lo_lt_hi    = (lo_q < hi_q);
  assign stat_o.key_eq      = (in_key == hkey);

  // Appended hash is written the cycle after capture, from hh_q/hl_q.
  logic             app_q, app_d;
  logic [IDX_W-1:0] app_addr_q, app_addr_d;
  assign hash_we    = app_q;
  assign hash_waddr = app_addr_q;

  always_comb begin
    tot_d = tot_q; i_d = i_q; cnt_d = cnt_q; pos_d = pos_q; chd_d = chd_q;
    lo_d = lo_q; hi_d = hi_q; mid_d = mid_q; rdy_d = rdy_q;
    hh_d = hh_q; hl_d = hl_q; rec_d = rec_q; crec_d = crec_q; c2rec_d = c2rec_q;
    rkey_d = rkey_q; ckey_d = ckey_q; st_d = st_q; ridx_d = ridx_q;
    app_d = 1'b0; app_addr_d = app_addr_q;
    idx_we = 1'b0; idx_waddr = '0; idx_wdata = '0; idx_raddr = '0;
    case (cmd_i.op)
      hrl_pkg::OP_ACCEPT: begin
        hh_d = hash_high_i;
        hl_d = hash_low_i;
        if (!op_i) begin
          rdy_d  = 1'b0;
          ridx_d = '0;
          if (tot_eff >= MAXC) begin
            tot_d = tot_eff;
            st_d  = hrl_pkg::ST_FULL;
          end else begin
            app_d      = 1'b1;
            app_addr_d = tot_eff[IDX_W-1:0];
            tot_d      = tot_eff + ONE;
            st_d       = hrl_pkg::ST_OK;
          end
        end else begin
          i_d  = '0;
          lo_d = '0;
          hi_d = tot_q;
          if (tot_q == '0) begin
            st_d   = hrl_pkg::ST_NF;
            ridx_d = '0;
          end
        end
      end
      hrl_pkg::OP_INIT: begin
        idx_we    = 1'b1;
        idx_waddr = i_q[IDX_W-1:0];
        idx_wdata = i_q[IDX_W-1:0];
        i_d       = stat_o.init_last ? (tot_q >> 1) : i_q + ONE;
      end
      hrl_pkg::OP_BCHK: begin
        if (i_q != '0) begin
          pos_d = im1;
          cnt_d = tot_q;
        end else begin
          i_d = tot_q;
        end
      end
      hrl_pkg::OP_DCHK: begin
        if (!stat_o.i_gt1) begin
          rdy_d = 1'b1;
          lo_d  = '0;
          hi_d  = tot_q;
        end
      end
      hrl_pkg::OP_SR0: idx_raddr = pos_q[IDX_W-1:0];
      hrl_pkg::OP_SR1: rec_d = idx_rdata;
      hrl_pkg::OP_SR2: rkey_d = hkey;
      hrl_pkg::OP_DR0: idx_raddr = '0;
      hrl_pkg::OP_DR1: begin
        crec_d    = idx_rdata;
        idx_raddr = im1[IDX_W-1:0];
      end
      hrl_pkg::OP_DR2: begin
        rec_d     = idx_rdata;
        idx_we    = 1'b1;
        idx_waddr = im1[IDX_W-1:0];
        idx_wdata = crec_q;
        cnt_d     = im1;
        pos_d     = '0;
      end
      hrl_pkg::OP_SL: begin
        chd_d     = chd_nx;
        idx_raddr = chd_nx[IDX_W-1:0];
      end
      hrl_pkg::OP_C1A: begin
        crec_d    = idx_rdata;
        idx_raddr = IDX_W'(chd_q + ONE);
      end
      hrl_pkg::OP_C1B: begin
        ckey_d  = hkey;
        c2rec_d = idx_rdata;
      end
      hrl_pkg::OP_C2: begin
        if (ckey_q < hkey) begin
          ckey_d = hkey;
          crec_d = c2rec_q;
          chd_d  = chd_q + ONE;
        end
      end
      hrl_pkg::OP_CMP: begin
        if (!stat_o.root_ge) begin
          idx_we    = 1'b1;
          idx_waddr = pos_q[IDX_W-1:0];
          idx_wdata = crec_q;
          pos_d     = chd_q;
        end
      end
      hrl_pkg::OP_SE: begin
        idx_we    = 1'b1;
        idx_waddr = pos_q[IDX_W-1:0];
        idx_wdata = rec_q;
        i_d       = im1;
      end
      hrl_pkg::OP_BS0: begin
        mid_d     = mid;
        idx_raddr = mid[IDX_W-1:0];
        if (!stat_o.lo_lt_hi) begin
          st_d   = hrl_pkg::ST_NF;
          ridx_d = '0;
        end
      end
      hrl_pkg::OP_BS1: crec_d = idx_rdata;
      hrl_pkg::OP_BS2: begin
        if (in_key < hkey) begin
          hi_d = mid_q;
        end else if (in_key > hkey) begin
          lo_d = mid_q + ONE;
        end else if (32'(crec_q) >= hrl_pkg::SURR_LO && 32'(crec_q) <= hrl_pkg::SURR_HI) begin
          st_d   = hrl_pkg::ST_NF;
          ridx_d = '0;
        end else begin
          st_d   = hrl_pkg::ST_OK;
          ridx_d = hrl_pkg::REC_IDX_W'(crec_q);
        end
      end
      default: begin
      end
    endcase
    if (!cmd_i.res_we) begin
      st_d   = st_q;
      ridx_d = ridx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q <= '0;
      rdy_q <= 1'b0;
      app_q <= 1'b0;
    end else begin
      tot_q <= tot_d;
      rdy_q <= rdy_d;
      app_q <= app_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; cnt_q <= cnt_d; pos_q <= pos_d; chd_q <= chd_d;
    lo_q <= lo_d; hi_q <= hi_d; mid_q <= mid_d;
    hh_q <= hh_d; hl_q <= hl_d; rec_q <= rec_d; crec_q <= crec_d; c2rec_q <= c2rec_d;
    rkey_q <= rkey_d; ckey_q <= ckey_d; st_q <= st_d; ridx_q <= ridx_d;
    app_addr_q <= app_addr_d;
  end

  assign status_o       = st_q;
  assign record_index_o = ridx_q;

endmodule

// ----- dv/hrl_tb_pkg.sv -----
package hrl_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_FIND = 1'b1
  } req_kind_e;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } hash_t;
endpackage

// ----- dv/hrl_checker.sv -----
module hrl_checker (
  input  logic        clk_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        op_i,
  input  logic [63:0] hash_high_i,
  input  logic [63:0] hash_low_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  status_i,
  input  logic [11:0] record_index_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 4096;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] rec;
  } reply_t;

  hrl_tb_pkg::hash_t table_q [DEPTH];
  int unsigned       order_q [DEPTH];
  int unsigned       rec_total;
  bit                built;
  reply_t            reply_fifo[$];

  function automatic int key_cmp(hrl_tb_pkg::hash_t k, int unsigned r);
    hrl_tb_pkg::hash_t o;
    o = table_q[r];
    if (k.hi != o.hi) return (k.hi < o.hi) ? -1 : 1;
    if (k.lo != o.lo) return (k.lo < o.lo) ? -1 : 1;
    return 0;
  endfunction

  task automatic sift(int unsigned cnt, int unsigned root);
    int unsigned ch;
    int unsigned t;
    while (root < cnt / 2) begin
      ch = root * 2 + 1;
      if (ch + 1 < cnt && key_cmp(table_q[order_q[ch]], order_q[ch + 1]) < 0) ch++;
      if (key_cmp(table_q[order_q[root]], order_q[ch]) >= 0) return;
      t = order_q[root];
      order_q[root] = order_q[ch];
      order_q[ch] = t;
      root = ch;
    end
  endtask

  task automatic heap_sort_index();
    int unsigned t;
    for (int unsigned i = 0; i < rec_total; i++) order_q[i] = i;
    for (int unsigned i = rec_total / 2; i != 0; i--) sift(rec_total, i - 1);
    for (int unsigned e = rec_total; e > 1; e--) begin
      t = order_q[0];
      order_q[0] = order_q[e - 1];
      order_q[e - 1] = t;
      sift(e - 1, 0);
    end
    built = 1;
  endtask

  task automatic predict_reply(logic op, hrl_tb_pkg::hash_t k);
    reply_t      rp;
    int unsigned lo, hi, mid, r;
    int          c;
    bit          done;
    rp   = '{status: hrl_pkg::ST_OK, rec: '0};
    done = 0;
    if (op == hrl_tb_pkg::REQ_LOAD) begin
      if (built) begin
        rec_total = 0;
        built = 0;
      end
      if (rec_total >= DEPTH) rp.status = hrl_pkg::ST_FULL;
      else begin
        table_q[rec_total] = k;
        rec_total++;
      end
    end else if (rec_total == 0) begin
      rp.status = hrl_pkg::ST_NF;
    end else begin
      if (!built) heap_sort_index();
      lo = 0;
      hi = rec_total;
      rp.status = hrl_pkg::ST_NF;
      while (lo < hi && !done) begin
        mid = lo + ((hi - lo) >> 1);
        r = order_q[mid];
        c = key_cmp(k, r);
        if (c < 0) hi = mid;
        else if (c > 0) lo = mid + 1;
        else begin
          done = 1;
          if (!(r >= hrl_pkg::SURR_LO && r <= hrl_pkg::SURR_HI)) begin
            rp.status = hrl_pkg::ST_OK;
            rp.rec = r[11:0];
          end
        end
      end
    end
    reply_fifo.push_back(rp);
  endtask

  always @(posedge clk_i) begin
    reply_t rp;
    if (in_valid_i && in_ready_i) predict_reply(op_i, '{hi: hash_high_i, lo: hash_low_i});
    if (out_valid_i && out_ready_i) begin
      if (reply_fifo.size() == 0) begin
        fail_count_o <= fail_count_o + 1;
        if (fail_count_o < 10)
          $display("unexpected response status=%0d rec=%0d", status_i, record_index_i);
      end else begin
        rp = reply_fifo.pop_front();
        if (status_i !== rp.status || record_index_i !== rp.rec) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10)
            $display("mismatch: exp status=%0d rec=%0d, got status=%0d rec=%0d",
                     rp.status, rp.rec, status_i, record_index_i);
        end
      end
    end
    pending_o <= reply_fifo.size();
  end
endmodule

// ----- dv/tb_hash_reverse_index_lookup.sv -----
module tb_hash_reverse_index_lookup;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic        op_i = hrl_tb_pkg::REQ_LOAD;
  logic [63:0] hash_high_i = '0;
  logic [63:0] hash_low_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic [1:0]  status_o;
  logic [11:0] record_index_o;
  int          fail_count;
  int          pending;

  bit                send_idle = 1;
  bit                recv_idle = 1;
  bit                long_hold = 0;
  int                req_count = 0;
  hrl_tb_pkg::hash_t loaded_q[$];

  always #5 clk_i = ~clk_i;

  hash_reverse_index_lookup dut (.*);

  hrl_checker u_checker (
    .clk_i, .in_valid_i, .in_ready_i(in_ready_o), .op_i, .hash_high_i, .hash_low_i,
    .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o),
    .record_index_i(record_index_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    #20ms;
    $display("hash_reverse_index_lookup verification failed");
    $finish;
  end

  // response side
  initial begin
    int w;
    @(posedge clk_i iff rst_ni);
    out_ready_i <= 1;
    forever begin
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      w = recv_idle ? $urandom_range(0, 12) : 0;
      if (long_hold) begin
        w = 400;
        long_hold = 0;
      end
      if (w > 0) begin
        out_ready_i <= 0;
        repeat (w) @(posedge clk_i);
        out_ready_i <= 1;
      end
    end
  end

  task automatic send(logic op, hrl_tb_pkg::hash_t k);
    int gap;
    gap = send_idle ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1;
    op_i        <= op;
    hash_high_i <= k.hi;
    hash_low_i  <= k.lo;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    if (op == hrl_tb_pkg::REQ_LOAD) loaded_q.push_back(k);
    req_count++;
  endtask

  task automatic drain();
    if (in_valid_i) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic hrl_tb_pkg::hash_t rand_hash();
    return '{hi: {$urandom, $urandom}, lo: {$urandom, $urandom}};
  endfunction

  function automatic hrl_tb_pkg::hash_t pick_key();
    hrl_tb_pkg::hash_t k;
    int                s;
    s = $urandom_range(0, 9);
    if (s < 6 && loaded_q.size() > 0) return loaded_q[$urandom_range(0, loaded_q.size() - 1)];
    k = rand_hash();
    if (s < 8 && loaded_q.size() > 0) begin
      k = loaded_q[$urandom_range(0, loaded_q.size() - 1)];
      k.lo ^= 64'd1 << $urandom_range(0, 63);
    end
    return k;
  endfunction

  initial begin
    hrl_tb_pkg::hash_t k;
    hrl_tb_pkg::hash_t pool[$];
    int                n, m;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed
    send(hrl_tb_pkg::REQ_FIND, '{hi: '1, lo: '1});
    pool = '{'{hi: '0, lo: '0}, '{hi: '1, lo: '1}, '{hi: '0, lo: '1},
             '{hi: '1, lo: '0}, '{hi: 64'h8000_0000_0000_0000, lo: 64'd1},
             '{hi: 64'h1234, lo: 64'h5678}, '{hi: 64'h1234, lo: 64'h5678},
             '{hi: 64'h1234, lo: 64'h5677}};
    foreach (pool[i]) send(hrl_tb_pkg::REQ_LOAD, pool[i]);
    foreach (pool[i]) send(hrl_tb_pkg::REQ_FIND, pool[i]);
    send(hrl_tb_pkg::REQ_FIND, '{hi: 64'h1234, lo: 64'h5679});
    send(hrl_tb_pkg::REQ_FIND, '{hi: 64'h7fff_ffff_ffff_ffff, lo: '1});
    drain();

    // random load/lookup batches
    while (req_count < 1950) begin
      send_idle = $urandom_range(0, 3) != 0;
      recv_idle = $urandom_range(0, 3) != 0;
      loaded_q.delete();
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      for (int i = 0; i < n; i++) begin
        if (loaded_q.size() > 0 && $urandom_range(0, 4) == 0)
          k = loaded_q[$urandom_range(0, loaded_q.size() - 1)];
        else if ($urandom_range(0, 3) == 0)
          k = '{hi: 64'($urandom_range(0, 3)), lo: {$urandom, $urandom}};
        else
          k = rand_hash();
        send(hrl_tb_pkg::REQ_LOAD, k);
      end
      m = $urandom_range(1, 25);
      if ($urandom_range(0, 12) == 0) long_hold = 1;
      for (int i = 0; i < m; i++) send(hrl_tb_pkg::REQ_FIND, pick_key());
      if ($urandom_range(0, 10) == 0) drain();
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("hash_reverse_index_lookup verification clean");
    else
      $display("hash_reverse_index_lookup verification failed");
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/hrl_pkg.sv
rtl/hrl_ram.sv
rtl/hrl_ctrl.sv
rtl/hrl_dp.sv
rtl/hash_reverse_index_lookup.sv
dv/hrl_tb_pkg.sv
dv/hrl_checker.sv
dv/tb_hash_reverse_index_lookup.sv
